// ----- rtl/hsfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfs_pkg
// Shared types and constants of the scaled HMM forward step.
// ----------------------------------------------------------------------------
package hsfs_pkg;

  localparam int NumStatesDef  = 8;
  localparam int NumSymbolsDef = 16;
  localparam int FracBitsDef   = 16;

  localparam int ProbW  = 17;
  localparam int WideW  = 20;
  localparam int OpW    = 2;
  localparam int RowW   = 3;
  localparam int ColW   = 4;
  localparam int SymW   = 4;
  localparam int NinW   = 4;
  localparam int NsymW  = 5;

  localparam logic [OpW-1:0] OP_LOAD_INIT  = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_TRANS = 2'd1;
  localparam logic [OpW-1:0] OP_LOAD_EMIT  = 2'd2;
  localparam logic [OpW-1:0] OP_OBSERVE    = 2'd3;

  localparam logic [0:0] REG_STATES  = 1'd0;
  localparam logic [0:0] REG_SYMBOLS = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT_RD,
    S_MAC,
    S_MUL_EM,
    S_ACCUM,
    S_DIV_START,
    S_DIV_RUN,
    S_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture request fields
    logic clr_acc;    // clear accumulator for a new destination
    logic mac;        // accumulate prev[l] * trans[l][i]
    logic mul_em;     // multiply by emission (or initial x emission)
    logic accum;      // store current alpha, add to scale
    logic clr_scale;
    logic div_start;
    logic div_step;
    logic div_done;   // store quotient into previous alphas
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_observe;
    logic start;
    logic div_last;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/hmm_scaled_forward_step_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_top
// Scaled HMM forward step: loads probability stores, runs one observation.
// ----------------------------------------------------------------------------
// Channel  Signals                        Direction
// in       in_valid / in_ready + fields   request in
// out      out_valid / out_ready + fields result out
// cfg      APB psel/penable/pwrite        register access
//
// An observation walks every used state through the shared multiply-accumulate,
// then divides each alpha by the scale on the single restoring divider and
// presents each result through the output handshake. Reset is synchronous;
// previous alphas clear at once. A stalled result holds the sequencer in its
// output state.
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step_top #(
  parameter int NUM_STATES     = hsfs_pkg::NumStatesDef,
  parameter int NUM_SYMBOLS    = hsfs_pkg::NumSymbolsDef,
  parameter int PROB_FRAC_BITS = hsfs_pkg::FracBitsDef
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [hsfs_pkg::OpW-1:0]      operation,
  input  wire [hsfs_pkg::RowW-1:0]     row_index,
  input  wire [hsfs_pkg::ColW-1:0]     column_index,
  input  wire [hsfs_pkg::ProbW-1:0]    prob_value,
  input  wire [hsfs_pkg::SymW-1:0]     symbol,
  input  wire                          start_of_sequence,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [hsfs_pkg::RowW-1:0]    state_index,
  output logic [hsfs_pkg::ProbW-1:0]   alpha_value,
  output logic [hsfs_pkg::WideW-1:0]   scale_factor,
  output logic                         impossible,
  output logic                         last_of_step,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [2:0]                    paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int IDX_W = $clog2(NUM_STATES);

  logic [hsfs_pkg::NinW-1:0]  states_reg;
  logic [hsfs_pkg::NsymW-1:0] symbols_reg;

  // Register writes
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      states_reg  <= hsfs_pkg::NinW'(8);
      symbols_reg <= hsfs_pkg::NsymW'(16);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == hsfs_pkg::REG_STATES) states_reg <= pwdata[hsfs_pkg::NinW-1:0];
      else symbols_reg <= pwdata[hsfs_pkg::NsymW-1:0];
    end
  end
  always_comb begin
    if (paddr[2] == hsfs_pkg::REG_STATES) prdata = 32'(states_reg);
    else prdata = 32'(symbols_reg);
  end

  // Clamp state count
  logic [IDX_W:0] n_used;
  always_comb begin
    if (states_reg == '0) n_used = (IDX_W+1)'(1);
    else if (32'(states_reg) > NUM_STATES) n_used = (IDX_W+1)'(NUM_STATES);
    else n_used = (IDX_W+1)'(states_reg);
  end

  hsfs_pkg::cmd_t  cmd;
  hsfs_pkg::stat_t stat;
  logic [IDX_W-1:0] dst, src;
  logic busy, last_dst, in_fire, out_free;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  hsfs_ctrl #(.NUM_STATES(NUM_STATES), .IDX_W(IDX_W)) u_ctrl (
    .clk, .rst, .in_fire, .out_free, .n_used, .stat, .cmd,
    .dst, .src, .busy, .last_dst
  );

  hsfs_dp #(
    .NUM_STATES(NUM_STATES), .NUM_SYMBOLS(NUM_SYMBOLS),
    .PROB_FRAC_BITS(PROB_FRAC_BITS), .IDX_W(IDX_W)
  ) u_dp (
    .clk, .rst, .cmd, .dst, .src, .last_dst, .n_used,
    .symbols_in_use(symbols_reg), .operation, .row_index, .column_index,
    .prob_value, .symbol, .start_of_sequence, .out_ready, .stat,
    .out_valid, .out_state(state_index), .out_alpha(alpha_value),
    .out_scale(scale_factor), .out_imp(impossible), .out_last(last_of_step)
  );

`ifndef SYNTHESIS
  a_imp_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (impossible == (scale_factor == '0)))
    else $error("impossible flag disagrees with scale");
  a_imp_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && impossible) |-> (alpha_value == '0))
    else $error("alpha non-zero on impossible step");
  a_busy_in: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready)
    else $error("request taken while busy");
`endif

endmodule
`default_nettype wire

// ----- rtl/hsfs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfs_ctrl
// Sequencer: walks states, source states and divider steps for one request.
// ----------------------------------------------------------------------------
module hsfs_ctrl #(
  parameter int NUM_STATES = hsfs_pkg::NumStatesDef,
  parameter int IDX_W      = 3
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_fire,
  input  wire                    out_free,
  input  wire [IDX_W:0]          n_used,
  input  hsfs_pkg::stat_t        stat,
  output hsfs_pkg::cmd_t         cmd,
  output logic [IDX_W-1:0]       dst,
  output logic [IDX_W-1:0]       src,
  output logic                   busy,
  output logic                   last_dst
);

  hsfs_pkg::state_t state, state_next;
  logic [IDX_W-1:0] dst_next, src_next;
  logic             src_last;

  assign last_dst = ({1'b0, dst} == n_used - 1'b1);
  assign src_last = ({1'b0, src} == n_used - 1'b1);

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsfs_pkg::S_IDLE;
      dst   <= '0;
      src   <= '0;
    end else begin
      state <= state_next;
      dst   <= dst_next;
      src   <= src_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    dst_next   = dst;
    src_next   = src;
    unique case (state)
      hsfs_pkg::S_IDLE: begin
        dst_next = '0;
        src_next = '0;
        if (in_fire) state_next = hsfs_pkg::S_EMIT_RD;
      end
      hsfs_pkg::S_EMIT_RD: begin
        if (!stat.is_observe) state_next = hsfs_pkg::S_IDLE;
        else if (stat.start) state_next = hsfs_pkg::S_MUL_EM;
        else state_next = hsfs_pkg::S_MAC;
      end
      hsfs_pkg::S_MAC: begin
        if (src_last) begin
          src_next   = '0;
          state_next = hsfs_pkg::S_MUL_EM;
        end else begin
          src_next = src + 1'b1;
        end
      end
      hsfs_pkg::S_MUL_EM: state_next = hsfs_pkg::S_ACCUM;
      hsfs_pkg::S_ACCUM: begin
        if (last_dst) begin
          dst_next   = '0;
          state_next = hsfs_pkg::S_DIV_START;
        end else begin
          dst_next   = dst + 1'b1;
          state_next = stat.start ? hsfs_pkg::S_MUL_EM : hsfs_pkg::S_MAC;
        end
      end
      hsfs_pkg::S_DIV_START: state_next = hsfs_pkg::S_DIV_RUN;
      hsfs_pkg::S_DIV_RUN: if (stat.div_last) state_next = hsfs_pkg::S_OUT;
      hsfs_pkg::S_OUT: begin
        if (out_free) begin
          if (last_dst) begin
            dst_next   = '0;
            state_next = hsfs_pkg::S_IDLE;
          end else begin
            dst_next   = dst + 1'b1;
            state_next = hsfs_pkg::S_DIV_START;
          end
        end
      end
      default: state_next = hsfs_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = (state != hsfs_pkg::S_IDLE);
    unique case (state)
      hsfs_pkg::S_IDLE: begin
        cmd.load      = in_fire;
        cmd.clr_acc   = 1'b1;
        cmd.clr_scale = 1'b1;
      end
      hsfs_pkg::S_EMIT_RD:   ;
      hsfs_pkg::S_MAC:       cmd.mac = 1'b1;
      hsfs_pkg::S_MUL_EM:    cmd.mul_em = 1'b1;
      hsfs_pkg::S_ACCUM: begin
        cmd.accum   = 1'b1;
        cmd.clr_acc = 1'b1;
      end
      hsfs_pkg::S_DIV_START: cmd.div_start = 1'b1;
      hsfs_pkg::S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        cmd.div_done = stat.div_last;
      end
      hsfs_pkg::S_OUT:       cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/hsfs_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfs_dp
// Datapath: probability stores, shared multiply-accumulate, restoring
// divider and result register.
// ----------------------------------------------------------------------------
module hsfs_dp #(
  parameter int NUM_STATES     = hsfs_pkg::NumStatesDef,
  parameter int NUM_SYMBOLS    = hsfs_pkg::NumSymbolsDef,
  parameter int PROB_FRAC_BITS = hsfs_pkg::FracBitsDef,
  parameter int IDX_W          = 3
) (
  input  wire                          clk,
  input  wire                          rst,
  input  hsfs_pkg::cmd_t               cmd,
  input  wire [IDX_W-1:0]              dst,
  input  wire [IDX_W-1:0]              src,
  input  wire                          last_dst,
  input  wire [IDX_W:0]                n_used,
  input  wire [hsfs_pkg::NsymW-1:0]    symbols_in_use,
  input  wire [hsfs_pkg::OpW-1:0]      operation,
  input  wire [hsfs_pkg::RowW-1:0]     row_index,
  input  wire [hsfs_pkg::ColW-1:0]     column_index,
  input  wire [hsfs_pkg::ProbW-1:0]    prob_value,
  input  wire [hsfs_pkg::SymW-1:0]     symbol,
  input  wire                          start_of_sequence,
  input  wire                          out_ready,
  output hsfs_pkg::stat_t              stat,
  output logic                         out_valid,
  output logic [hsfs_pkg::RowW-1:0]    out_state,
  output logic [hsfs_pkg::ProbW-1:0]   out_alpha,
  output logic [hsfs_pkg::WideW-1:0]   out_scale,
  output logic                         out_imp,
  output logic                         out_last
);

  localparam int PW     = hsfs_pkg::ProbW;
  localparam int WW     = hsfs_pkg::WideW;
  localparam int SYM_W  = $clog2(NUM_SYMBOLS);
  localparam int ACC_W  = WW + IDX_W + 1;
  localparam int NUM_W  = WW + PROB_FRAC_BITS;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam logic [PW-1:0] ONE = PW'(1) << PROB_FRAC_BITS;
  localparam logic [WW-1:0] WMAX = '1;

  // Memories
  logic [PW-1:0] init_mem  [NUM_STATES];
  logic [PW-1:0] trans_mem [NUM_STATES*NUM_STATES];
  logic [PW-1:0] emit_mem  [NUM_STATES*NUM_SYMBOLS];
  logic [PW-1:0] prev      [NUM_STATES];
  logic [WW-1:0] cur       [NUM_STATES];

  // Captured request
  logic [hsfs_pkg::OpW-1:0]  op_q;
  logic [hsfs_pkg::RowW-1:0] row_q;
  logic [hsfs_pkg::ColW-1:0] col_q;
  logic [PW-1:0]             prob_q;
  logic [hsfs_pkg::SymW-1:0] sym_q;
  logic                      start_q;

  logic [PW-1:0] prob_sat;
  assign prob_sat = (prob_value > ONE) ? ONE : prob_value;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      row_q   <= row_index;
      col_q   <= column_index;
      prob_q  <= prob_sat;
      sym_q   <= symbol;
      start_q <= start_of_sequence;
    end
  end

  assign stat.is_observe = (op_q == hsfs_pkg::OP_OBSERVE);
  assign stat.start      = start_q;

  // Store writes, in the cycle after capture
  logic wr_en;
  assign wr_en = cmd.load;
  logic wr_pend;
  always_ff @(posedge clk) begin
    if (rst) wr_pend <= 1'b0;
    else     wr_pend <= wr_en;
  end

  logic row_ok, tcol_ok, ecol_ok;
  assign row_ok  = (32'(row_q) < NUM_STATES);
  assign tcol_ok = (32'(col_q) < NUM_STATES);
  assign ecol_ok = (32'(col_q) < NUM_SYMBOLS);

  always_ff @(posedge clk) begin
    if (wr_pend && row_ok) begin
      if (op_q == hsfs_pkg::OP_LOAD_INIT)
        init_mem[row_q[IDX_W-1:0]] <= prob_q;
      if (op_q == hsfs_pkg::OP_LOAD_TRANS && tcol_ok)
        trans_mem[{row_q[IDX_W-1:0], col_q[IDX_W-1:0]}] <= prob_q;
      if (op_q == hsfs_pkg::OP_LOAD_EMIT && ecol_ok)
        emit_mem[{row_q[IDX_W-1:0], col_q[SYM_W-1:0]}] <= prob_q;
    end
  end

  // Clamped symbol count
  logic [hsfs_pkg::NsymW:0] nsym;
  always_comb begin
    if (symbols_in_use == '0) nsym = (hsfs_pkg::NsymW+1)'(1);
    else if (32'(symbols_in_use) > NUM_SYMBOLS) nsym = (hsfs_pkg::NsymW+1)'(NUM_SYMBOLS);
    else nsym = {1'b0, symbols_in_use};
  end

  // Registered store reads
  logic [PW-1:0] em_rd, init_rd, tr_rd, pv_rd;
  logic          sym_ok;
  assign sym_ok = ({2'b0, sym_q} < nsym);
  always_ff @(posedge clk) begin
    em_rd   <= sym_ok ? emit_mem[{dst, sym_q[SYM_W-1:0]}] : '0;
    init_rd <= init_mem[dst];
    tr_rd   <= trans_mem[{src, dst}];
    pv_rd   <= prev[src];
  end

  // Truncating fixed-point multiply, p <= 1.0
  function automatic logic [WW-1:0] mulfix(input logic [WW-1:0] x, input logic [PW-1:0] p);
    logic [WW+PW-1:0] pr;
    begin
      pr = {{PW{1'b0}}, x} * {{WW{1'b0}}, p};
      mulfix = (p >= ONE) ? x : WW'(pr >> PROB_FRAC_BITS);
    end
  endfunction

  // MAC pipeline: read registered above, product registered, then add
  logic          mac_d1, mac_d2;
  logic [WW-1:0] prod;
  logic [ACC_W-1:0] acc, acc_fin;
  always_ff @(posedge clk) begin
    mac_d1 <= cmd.mac;
    mac_d2 <= mac_d1;
    prod   <= mulfix(WW'(pv_rd), tr_rd);
  end

  // The last source product is still in the product register when the
  // current alpha is stored, so fold it into the sum there
  assign acc_fin = mac_d2 ? acc + ACC_W'(prod) : acc;
  always_ff @(posedge clk) begin
    if (cmd.clr_acc) acc <= '0;
    else if (mac_d2) acc <= acc + ACC_W'(prod);
  end

  // Emission multiply on the completed sum
  logic          mul_d1;
  logic [WW-1:0] acc_sat, cur_val;
  assign acc_sat = (acc_fin > ACC_W'(WMAX)) ? WMAX : WW'(acc_fin);
  always_ff @(posedge clk) begin
    mul_d1 <= cmd.mul_em;
  end

  logic [WW:0]   scale_sum;
  logic [WW-1:0] scale;
  assign cur_val = start_q ? mulfix(WW'(init_rd), em_rd) : mulfix(acc_sat, em_rd);
  always_ff @(posedge clk) begin
    if (cmd.accum) cur[dst] <= cur_val;
  end

  // Add the alpha stored on the previous cycle into the scale
  logic acc_d1;
  logic [IDX_W-1:0] dst_d1;
  always_ff @(posedge clk) begin
    acc_d1 <= cmd.accum;
    dst_d1 <= dst;
  end
  assign scale_sum = {1'b0, scale} + {1'b0, cur[dst_d1]};
  always_ff @(posedge clk) begin
    if (cmd.clr_scale) scale <= '0;
    else if (acc_d1) scale <= scale_sum[WW] ? WMAX : scale_sum[WW-1:0];
  end

  // Restoring divider: (cur << F) / scale, one quotient bit a cycle
  logic [NUM_W-1:0] dnum, quo;
  logic [WW:0]      rem, rem_sh;
  logic [CNT_W-1:0] dcnt;
  assign rem_sh = {rem[WW-1:0], dnum[NUM_W-1]};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dnum <= {cur[dst], {PROB_FRAC_BITS{1'b0}}};
      rem  <= '0;
      quo  <= '0;
      dcnt <= CNT_W'(NUM_W - 1);
    end else if (cmd.div_step) begin
      dnum <= dnum << 1;
      dcnt <= dcnt - 1'b1;
      if (rem_sh >= {1'b0, scale}) begin
        rem <= rem_sh - {1'b0, scale};
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end
  assign stat.div_last = (dcnt == '0);

  logic [PW-1:0] alpha_q;
  logic          q_bit;
  logic [NUM_W-1:0] quo_fin;
  assign q_bit   = (rem_sh >= {1'b0, scale});
  assign quo_fin = {quo[NUM_W-2:0], q_bit};
  assign alpha_q = (scale == '0) ? '0 : PW'(quo_fin);

  // Previous alphas; cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_STATES; k++) prev[k] <= '0;
    end else if (cmd.div_done) begin
      prev[dst] <= alpha_q;
    end
  end

  logic [PW-1:0] alpha_hold;
  always_ff @(posedge clk) begin
    if (cmd.div_done) alpha_hold <= alpha_q;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_state <= hsfs_pkg::RowW'(dst);
      out_alpha <= alpha_hold;
      out_scale <= scale;
      out_imp   <= (scale == '0);
      out_last  <= last_dst;
    end
  end

  logic unused;
  assign unused = ^{n_used, mul_d1, mac_d1};

endmodule
`default_nettype wire

// ----- sim/hmm_scaled_forward_step_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_top_test
// Drives load and observe requests into the scaled forward step, keeps its
// own fixed-point forward model and checks every scaled alpha it returns.
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step_top_test;

  localparam int OpW   = hsfs_pkg::OpW;
  localparam int RowW  = hsfs_pkg::RowW;
  localparam int ColW  = hsfs_pkg::ColW;
  localparam int ProbW = hsfs_pkg::ProbW;
  localparam int SymW  = hsfs_pkg::SymW;
  localparam int WideW = hsfs_pkg::WideW;
  localparam int NinW  = hsfs_pkg::NinW;
  localparam int NsymW = hsfs_pkg::NsymW;
  localparam int FracBits = hsfs_pkg::FracBitsDef;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 60;
  localparam logic [2:0] AddrStates  = 3'(hsfs_pkg::REG_STATES) * 3'd4;
  localparam logic [2:0] AddrSymbols = 3'(hsfs_pkg::REG_SYMBOLS) * 3'd4;

  typedef struct {
    logic [RowW-1:0]  state;
    logic [ProbW-1:0] alpha;
    logic [WideW-1:0] scale;
    logic             impossible;
    logic             last;
  } alpha_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OpW-1:0] operation = hsfs_pkg::OP_LOAD_INIT;
  logic [RowW-1:0] row_index = '0;
  logic [ColW-1:0] column_index = '0;
  logic [ProbW-1:0] prob_value = '0;
  logic [SymW-1:0] symbol = '0;
  logic start_of_sequence = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RowW-1:0] state_index;
  logic [ProbW-1:0] alpha_value;
  logic [WideW-1:0] scale_factor;
  logic impossible;
  logic last_of_step;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // model copy of the block
  logic [ProbW-1:0] init_prob [8];
  logic [ProbW-1:0] trans_prob [64];
  logic [ProbW-1:0] emit_prob [128];
  logic [ProbW-1:0] prev_alpha [8];
  logic [NinW-1:0] states_reg = 4'd8;
  logic [NsymW-1:0] symbols_reg = 5'd16;

  alpha_result_t pending_alphas[$];
  int mismatches = 0;
  int cycles = 0;
  bit idling = 1'b1;
  bit hold_request = 1'b0;

  hmm_scaled_forward_step_top dut (.*);

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("hmm_scaled_forward_step_top_test: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    alpha_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_alphas.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: state %0d alpha %0d", state_index, alpha_value);
      end else begin
        want = pending_alphas.pop_front();
        if (state_index !== want.state || alpha_value !== want.alpha ||
            scale_factor !== want.scale || impossible !== want.impossible ||
            last_of_step !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st %0d a %0d sc %0d imp %0b last %0b,",
                      " got %0d %0d %0d %0b %0b"},
                     want.state, want.alpha, want.scale, want.impossible, want.last,
                     state_index, alpha_value, scale_factor, impossible, last_of_step);
        end
      end
    end
  end

  function automatic logic [63:0] fix_mul(logic [63:0] x, logic [63:0] p);
    return (x * p) >> FracBits;
  endfunction

  // forward step of the model: queue one result per used state
  function automatic void forward_step(logic [SymW-1:0] sym, logic first);
    logic [63:0] cur [8];
    logic [63:0] acc, em, scale, a;
    int n, nsym;
    alpha_result_t r;
    n = (states_reg < 1) ? 1 : (states_reg > 8) ? 8 : int'(states_reg);
    nsym = (symbols_reg < 1) ? 1 : (symbols_reg > 16) ? 16 : int'(symbols_reg);
    scale = 0;
    for (int i = 0; i < n; i++) begin
      em = (sym < nsym) ? 64'(emit_prob[i*16 + sym]) : 64'd0;
      if (first) begin
        cur[i] = fix_mul(64'(init_prob[i]), em);
      end else begin
        acc = 0;
        for (int l = 0; l < n; l++)
          acc += fix_mul(64'(prev_alpha[l]), 64'(trans_prob[l*8 + i]));
        cur[i] = fix_mul(acc, em);
      end
      if (cur[i] > 64'hFFFFF) cur[i] = 64'hFFFFF;
      scale = scale + cur[i];
      if (scale > 64'hFFFFF) scale = 64'hFFFFF;
    end
    for (int i = 0; i < n; i++) begin
      a = (scale != 0) ? (cur[i] << FracBits) / scale : 64'd0;
      prev_alpha[i] = a[ProbW-1:0];
      r.state = RowW'(i);
      r.alpha = a[ProbW-1:0];
      r.scale = scale[WideW-1:0];
      r.impossible = (scale == 0);
      r.last = (i + 1 == n);
      pending_alphas.push_back(r);
    end
  endfunction

  // send one request and update the model when it is taken
  task automatic send_request(logic [OpW-1:0] op, logic [RowW-1:0] row,
                              logic [ColW-1:0] col, logic [ProbW-1:0] prob,
                              logic [SymW-1:0] sym, logic first);
    logic [ProbW-1:0] p;
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    operation <= op;
    row_index <= row;
    column_index <= col;
    prob_value <= prob;
    symbol <= sym;
    start_of_sequence <= first;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    p = (prob > 17'h10000) ? 17'h10000 : prob;
    case (op)
      hsfs_pkg::OP_LOAD_INIT: init_prob[row] = p;
      hsfs_pkg::OP_LOAD_TRANS: if (col < 8) trans_prob[row*8 + col] = p;
      hsfs_pkg::OP_LOAD_EMIT: emit_prob[row*16 + col] = p;
      default: forward_step(sym, first);
    endcase
  endtask

  task automatic observe(logic [SymW-1:0] sym, logic first);
    send_request(hsfs_pkg::OP_OBSERVE, RowW'($urandom), ColW'($urandom),
                 ProbW'($urandom), sym, first);
  endtask

  // wait until the block has gone quiet
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_alphas.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrStates) states_reg = value[NinW-1:0];
    else symbols_reg = value[NsymW-1:0];
    @(posedge clk);
  endtask

  function automatic logic [ProbW-1:0] random_prob();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 17'h10000;
      2: return ProbW'($urandom_range(17'h10001, 17'h1FFFF));
      default: return ProbW'($urandom_range(1, 17'h10000));
    endcase
  endfunction

  // fill every store entry so no unwritten entry is ever read
  task automatic test_fill_stores;
    for (int i = 0; i < 8; i++)
      send_request(hsfs_pkg::OP_LOAD_INIT, RowW'(i), ColW'(0), random_prob(), SymW'(0), 1'b0);
    for (int i = 0; i < 64; i++)
      send_request(hsfs_pkg::OP_LOAD_TRANS, RowW'(i / 8), ColW'(i % 8), random_prob(),
                   SymW'(0), 1'b0);
    for (int i = 0; i < 128; i++)
      send_request(hsfs_pkg::OP_LOAD_EMIT, RowW'(i / 16), ColW'(i % 16),
                   ProbW'($urandom_range(1, 17'h1FFFF)), SymW'(0), 1'b0);
  endtask

  // extremes and special cases
  task automatic test_directed;
    observe(4'd3, 1'b0);                    // continuation straight after reset
    observe(4'd15, 1'b1);
    observe(4'd0, 1'b0);
    // out of store: dropped
    send_request(hsfs_pkg::OP_LOAD_TRANS, 3'd7, 4'd15, 17'h1FFFF, 4'd0, 1'b0);
    // saturates to one
    send_request(hsfs_pkg::OP_LOAD_INIT, 3'd7, 4'd0, 17'h1FFFF, 4'd0, 1'b0);
    for (int i = 0; i < 8; i++)
      send_request(hsfs_pkg::OP_LOAD_EMIT, RowW'(i), 4'd9, 17'h0, 4'd0, 1'b0);
    observe(4'd9, 1'b1);                    // zero scale
    observe(4'd1, 1'b0);                    // continuation after an impossible step
    observe(4'd1, 1'b1);
    observe(4'd2, 1'b0);
    drain();
    write_register(AddrSymbols, 32'd4);
    observe(4'd4, 1'b1);                    // symbol past the used range
    observe(4'd3, 1'b1);
    drain();
    write_register(AddrStates, 32'd0);      // acts as one state
    write_register(AddrSymbols, 32'd0);
    observe(4'd0, 1'b1);
    observe(4'd0, 1'b0);
    drain();
    write_register(AddrStates, 32'd15);     // clamps to all states
    write_register(AddrSymbols, 32'd31);
    observe(4'd15, 1'b1);
    observe(4'd8, 1'b0);
    drain();
  endtask

  // well-formed sequences with random content, some loads and noise
  task automatic run_sequences(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(hsfs_pkg::OP_LOAD_INIT + OpW'($urandom_range(0, 2)), RowW'($urandom),
                     ColW'($urandom), random_prob(), SymW'(0), 1'b0);
        sent++;
      end else if ($urandom_range(0, 9) == 0) begin
        observe(SymW'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        observe(SymW'($urandom_range(0, 15)), 1'b1);
        sent++;
        repeat ($urandom_range(1, 6)) begin
          observe(SymW'($urandom_range(0, 15)), 1'b0);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random;
    for (int phase = 0; phase < 5; phase++) begin
      write_register(AddrStates, (phase == 0) ? 32'd8 : 32'($urandom_range(1, 8)));
      write_register(AddrSymbols, (phase == 1) ? 32'd1 : 32'($urandom_range(1, 16)));
      run_sequences(15);
      drain();
    end
  endtask

  // long receiver hold while requests keep coming, then a full pause
  task automatic test_backpressure;
    write_register(AddrStates, 32'd8);
    write_register(AddrSymbols, 32'd16);
    hold_request = 1'b1;
    run_sequences(12);
    in_valid <= 1'b0;
    while (pending_alphas.size() != 0) @(posedge clk);
    run_sequences(12);
    drain();
  endtask

  task automatic test_no_idling;
    idling = 1'b0;
    write_register(AddrStates, 32'd5);
    run_sequences(30);
    drain();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) prev_alpha[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_stores();
    test_directed();
    test_random();
    test_backpressure();
    test_no_idling();
    if (mismatches == 0 && pending_alphas.size() == 0)
      $display("hmm_scaled_forward_step_top_test: clean");
    else
      $display("hmm_scaled_forward_step_top_test: errors");
    $finish;
  end

endmodule
